>>> src/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants of the permutation shuffle block.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int CNT_W     = 9;
  localparam int RAND_W    = 32;
  localparam int OUT_W     = 8;
  localparam int DIV_BITS  = 2;
  localparam int DIV_CYC   = RAND_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DIV,
    S_RDJ,
    S_SWAP,
    S_OUT
  } rps_state_e;

endpackage

>>> src/random_permutation_shuffle_top.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffle_top
// Forward Fisher-Yates shuffle of 0..count-1, one random word per position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one random word per item.
//   Output channel (out_valid_o / out_stall_i) returns one item per input:
//   the element now final at this position, the position, and a last flag
//   on the final element of each permutation; the next item starts over.
//   cfg_we_i writes item_count (0 acts as 1, values above MAX_ELEMENTS
//   saturate) and abandons any permutation in progress.
//   An accepted word passes the remainder unit (two bits a cycle) and its
//   done step, then the read, swap and output load states on the table
//   memory, which has one write port and one read port. One item is in
//   flight at a time; the next is taken once the output register is loaded.
//   Reset and every config write start a clearing pass over all
//   min(MAX_ELEMENTS, 512) table entries, during which in_stall_o is high.
//   A stalled output holds its item; the next input is still accepted and
//   worked on, and waits at the end until the output register frees up.
// ----------------------------------------------------------------------------
module random_permutation_shuffle_top #(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rps_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rps_pkg::RAND_W-1:0]  random_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rps_pkg::OUT_W-1:0]   element_o,
  output logic [rps_pkg::OUT_W-1:0]   position_o,
  output logic                        last_o
);
  import rps_pkg::*;

  localparam int DEPTH   = (MAX_ELEMENTS < 2**CNT_W) ? MAX_ELEMENTS : 2**CNT_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_RST = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;

  rps_state_e     state_q, state_d;
  cnt_t           n_q;
  cnt_t           cur_pos_q;
  cnt_t           i_q;
  cnt_t           span_q;
  cnt_t           j_q;
  cnt_t           a_q;
  cnt_t           b_q;
  cnt_t           n_cfg;
  cnt_t           i_start;
  logic [AW-1:0]  clr_q;

  logic [CNT_W:0] mem [DEPTH];
  logic [CNT_W:0] rdata_q;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [AW-1:0]  mem_ra;
  logic [CNT_W:0] mem_wd;
  cnt_t           rd_val;

  logic           in_acc;
  logic           out_load;
  logic           div_done;
  cnt_t           div_rem;
  logic           is_last;

  logic           out_valid_q;
  logic [OUT_W-1:0] elem_q;
  cnt_t           pos_q;
  logic           last_q;

  assign in_acc  = in_valid_i && (state_q == S_IDLE) && !cfg_we_i;
  assign i_start = (cur_pos_q >= n_q) ? '0 : cur_pos_q;
  assign is_last = (i_q == n_q - 1'b1);
  assign rd_val  = rdata_q[CNT_W-1:0];

  always_comb begin
    n_cfg = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      n_cfg = cnt_t'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_ELEMENTS)) begin
      n_cfg = CNT_W'(MAX_ELEMENTS);
    end
  end

  rps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (random_word_i),
    .divisor_i  (n_q - i_start),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d  = state_q;
    mem_we   = 1'b0;
    mem_wa   = AW'(i_q);
    mem_wd   = '0;
    mem_ra   = AW'(i_q);
    out_load = 1'b0;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_ra = AW'(i_start);
        if (in_acc) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_RDJ;
        end
      end
      S_RDJ: begin
        // entry i is final after this item: mark it unwritten again
        mem_ra  = AW'(j_q);
        mem_we  = 1'b1;
        state_d = S_SWAP;
      end
      S_SWAP: begin
        mem_we  = (j_q != i_q);
        mem_wa  = AW'(j_q);
        mem_wd  = {1'b1, a_q};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
    if (cfg_we_i) begin
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      n_q         <= CNT_W'(CNT_RST);
      cur_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        n_q       <= n_cfg;
        cur_pos_q <= '0;
        clr_q     <= '0;
      end else begin
        if (state_q == S_CLR) begin
          clr_q <= clr_q + 1'b1;
        end
        if (out_load) begin
          cur_pos_q <= is_last ? '0 : i_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      i_q    <= i_start;
      span_q <= n_q - i_start;
    end
    if (state_q == S_DIV && div_done) begin
      j_q <= div_rem + i_q;
    end
    if (state_q == S_RDJ) begin
      a_q <= rdata_q[CNT_W] ? rd_val : i_q;
    end
    if (state_q == S_SWAP) begin
      b_q <= rdata_q[CNT_W] ? rd_val : j_q;
    end
    if (out_load) begin
      elem_q <= b_q[OUT_W-1:0];
      pos_q  <= i_q;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  assign in_stall_o  = (state_q != S_IDLE) || cfg_we_i;
  assign out_valid_o = out_valid_q;
  assign element_o   = elem_q;
  assign position_o  = pos_q[OUT_W-1:0];
  assign last_o      = last_q;

`ifndef SYNTH
  a_partner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP |-> (j_q >= i_q) && (j_q < n_q))
    else $error("swap partner out of range");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && div_done |-> div_rem < span_q)
    else $error("remainder not below span");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (last_q == (pos_q == n_q - 1'b1)) || $past(cfg_we_i))
    else $error("last flag disagrees with position");
`endif

endmodule

>>> src/rps_rem.sv
// ----------------------------------------------------------------------------
// rps_rem
// Iterative remainder of a 32-bit word by a 9-bit divisor, two bits a cycle.
// ----------------------------------------------------------------------------
module rps_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rps_pkg::RAND_W-1:0]  dividend_i,
  input  rps_pkg::cnt_t               divisor_i,
  output logic                        done_o,
  output rps_pkg::cnt_t               rem_o
);
  import rps_pkg::*;

  logic [RAND_W-1:0]    word_q;
  cnt_t                 div_q;
  cnt_t                 rem_q;
  cnt_t                 rem_d;
  logic [CNT_W:0]       trial;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  always_comb begin
    rem_d = rem_q;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_d, word_q[RAND_W-1-k]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 1'b1;
      done_q <= (cnt_q == DIV_CNT_W'(DIV_CYC - 1));
      busy_q <= (cnt_q != DIV_CNT_W'(DIV_CYC - 1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      word_q <= dividend_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      word_q <= word_q << DIV_BITS;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> tb/random_permutation_shuffle_checker.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffle_checker
// Watches the count writes and both item channels of the shuffle block. It
// keeps its own shuffle table, predicts each emitted element and compares the
// results in order.
// ----------------------------------------------------------------------------
module random_permutation_shuffle_checker #(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  rps_pkg::cnt_t               cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [rps_pkg::RAND_W-1:0]  random_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [rps_pkg::OUT_W-1:0]   element_i,
  input  logic [rps_pkg::OUT_W-1:0]   position_i,
  input  logic                        last_i,
  output int                          mismatch_count_o,
  output int                          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [rps_pkg::OUT_W-1:0] element;
    logic [rps_pkg::OUT_W-1:0] position;
    logic                      last;
  } shuffle_res_t;

  shuffle_res_t              shuffled_q[$];
  shuffle_res_t              want;
  logic [rps_pkg::OUT_W-1:0] slot_value [MAX_ELEMENTS];
  bit                        slot_written [MAX_ELEMENTS];
  int unsigned               next_slot;
  rps_pkg::cnt_t             elem_count;
  int                        mismatches = 0;

  function automatic void restart_shuffle();
    foreach (slot_written[k]) slot_written[k] = 1'b0;
    next_slot = 0;
  endfunction

  function automatic logic [rps_pkg::OUT_W-1:0] read_slot(int unsigned idx);
    return slot_written[idx] ? slot_value[idx] : idx[rps_pkg::OUT_W-1:0];
  endfunction

  function automatic shuffle_res_t shuffle_next(logic [rps_pkg::RAND_W-1:0] word);
    shuffle_res_t res;
    int unsigned  n;
    int unsigned  i;
    int unsigned  partner;
    logic [rps_pkg::OUT_W-1:0] a;
    logic [rps_pkg::OUT_W-1:0] b;
    n = elem_count;
    if (n == 0) n = 1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    i = next_slot;
    if (i >= n) i = 0;
    partner = (word % (n - i)) + i;
    a = read_slot(i);
    b = read_slot(partner);
    slot_value[i]         = b;
    slot_written[i]       = 1'b1;
    slot_value[partner]   = a;
    slot_written[partner] = 1'b1;
    res.element  = b;
    res.position = i[rps_pkg::OUT_W-1:0];
    res.last     = (i == n - 1);
    if (res.last) restart_shuffle();
    else next_slot = i + 1;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count = 9'd256;
      restart_shuffle();
      shuffled_q.delete();
      pending_count_o  <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        elem_count = cfg_wdata_i;
        restart_shuffle();
      end
      if (out_valid_i && !out_stall_i) begin
        if (shuffled_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual element %0d position %0d last %0d",
                   $time, element_i, position_i, last_i);
          mismatches++;
        end else begin
          want = shuffled_q.pop_front();
          check_field("element", want.element, element_i);
          check_field("position", want.position, position_i);
          check_field("last", want.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) shuffled_q.push_back(shuffle_next(random_word_i));
      pending_count_o  <= shuffled_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> tb/random_permutation_shuffle_top_tb.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffle_top_tb
// Drives count writes and random words into the shuffle block under several
// idle and stall mixes, including a long output hold-off, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module random_permutation_shuffle_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 256;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 82;
  localparam int HOLD_CYCLES  = 400;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  rps_pkg::cnt_t               cfg_wdata_i   = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [rps_pkg::RAND_W-1:0]  random_word_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [rps_pkg::OUT_W-1:0]   element_o;
  logic [rps_pkg::OUT_W-1:0]   position_o;
  logic                        last_o;

  int mismatch_count;
  int pending_count;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_on    = 1'b0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  random_permutation_shuffle_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .random_word_i(random_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .element_o    (element_o),
    .position_o   (position_o),
    .last_o       (last_o)
  );

  random_permutation_shuffle_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .random_word_i   (random_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_i       (element_o),
    .position_i      (position_o),
    .last_i          (last_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: random stall, plus one long hold-off in the pressure phase
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_word(input logic [rps_pkg::RAND_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_count(input rps_pkg::cnt_t value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [rps_pkg::RAND_W-1:0] pick_word();
    case ($urandom_range(4))
      0: return $urandom_range(0, 600);
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic rps_pkg::cnt_t pick_count(int phase);
    case (phase)
      0: return 9'd256;
      1: return 9'd1;
      2: return 9'd0;
      3: return 9'd511;
      default: begin
        if ($urandom_range(4) == 0) return rps_pkg::cnt_t'($urandom_range(0, 511));
        return rps_pkg::cnt_t'($urandom_range(2, 24));
      end
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset count, field extremes, zero and oversized counts,
    // tiny permutations, and writes that abandon a permutation midway
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0001);
    push_word(32'h8000_0000);
    push_word(32'h7FFF_FFFF);
    push_word(32'd255);
    push_word(32'd256);
    push_word(32'hAAAA_AAAA);
    push_word(32'h5555_5555);
    write_count(9'd0);
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word($urandom);
    write_count(9'd511);
    push_word(32'hFFFF_FFFF);
    push_word(32'd300);
    write_count(9'd1);
    push_word(32'd7);
    push_word(32'hFFFF_FFFF);
    write_count(9'd2);
    push_word(32'd0);
    push_word(32'd1);
    push_word(32'd1);
    push_word(32'hFFFF_FFFF);
    write_count(9'd3);
    push_word(32'd2);
    push_word(32'd1);
    push_word(32'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_count(pick_count(phase));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct = 38; recv_stall_pct <= 38; end
      endcase
      if (phase == 4) pressure_on <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) push_word(pick_word());
      pressure_on <= 1'b0;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
